// File: sv/tgpr_pkg.sv
// shared types, constants and the 8x8 font table for the text glyph pixel renderer
package tgpr_pkg;

  localparam int GLYPH_SIZE  = 8;
  localparam int GLYPH_BITS  = GLYPH_SIZE * GLYPH_SIZE;
  localparam int PRINT_FIRST = 32;
  localparam int PRINT_COUNT = 95;

  localparam int MARGIN    = 10;
  localparam int LINE_PAD  = 5;
  localparam int TAB_CELLS = 4;

  localparam int SW_W  = 13;
  localparam int CUR_W = 16;
  localparam int PIX_W = 17;
  localparam int COL_W = 24;
  localparam int OP_W  = 2;
  localparam int CODE_W = 7;

  localparam logic [SW_W-1:0]   SCREEN_WIDTH_RST = 13'd1024;
  localparam logic [CODE_W-1:0] CODE_NEWLINE     = 7'd10;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW      = 2'd0,
    OP_NEWLINE   = 2'd1,
    OP_BACKSPACE = 2'd2,
    OP_TAB       = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_NEWLINE,
    CUR_ADVANCE,
    CUR_BACKSPACE,
    CUR_TAB_WRAP
  } cur_cmd_t;

  // printable codes 32..126, rows top to bottom, bit 0 is the leftmost column
  localparam logic [7:0] FONT_GLYPHS [PRINT_COUNT][GLYPH_SIZE] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h18,8'h3C,8'h3C,8'h18,8'h18,8'h00,8'h18,8'h00},
    '{8'h36,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h36,8'h36,8'h7F,8'h36,8'h7F,8'h36,8'h36,8'h00},
    '{8'h0C,8'h3E,8'h03,8'h1E,8'h30,8'h1F,8'h0C,8'h00},
    '{8'h00,8'h63,8'h33,8'h18,8'h0C,8'h66,8'h63,8'h00},
    '{8'h1C,8'h36,8'h1C,8'h6E,8'h3B,8'h33,8'h6E,8'h00},
    '{8'h06,8'h06,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h18,8'h0C,8'h06,8'h06,8'h06,8'h0C,8'h18,8'h00},
    '{8'h06,8'h0C,8'h18,8'h18,8'h18,8'h0C,8'h06,8'h00},
    '{8'h00,8'h66,8'h3C,8'hFF,8'h3C,8'h66,8'h00,8'h00},
    '{8'h00,8'h0C,8'h0C,8'h3F,8'h0C,8'h0C,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h06},
    '{8'h00,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h00},
    '{8'h60,8'h30,8'h18,8'h0C,8'h06,8'h03,8'h01,8'h00},
    '{8'h3E,8'h63,8'h73,8'h7B,8'h6F,8'h67,8'h3E,8'h00},
    '{8'h0C,8'h0E,8'h0C,8'h0C,8'h0C,8'h0C,8'h3F,8'h00},
    '{8'h1E,8'h33,8'h30,8'h1C,8'h06,8'h33,8'h3F,8'h00},
    '{8'h1E,8'h33,8'h30,8'h1C,8'h30,8'h33,8'h1E,8'h00},
    '{8'h38,8'h3C,8'h36,8'h33,8'h7F,8'h30,8'h78,8'h00},
    '{8'h3F,8'h03,8'h1F,8'h30,8'h30,8'h33,8'h1E,8'h00},
    '{8'h1C,8'h06,8'h03,8'h1F,8'h33,8'h33,8'h1E,8'h00},
    '{8'h3F,8'h33,8'h30,8'h18,8'h0C,8'h0C,8'h0C,8'h00},
    '{8'h1E,8'h33,8'h33,8'h1E,8'h33,8'h33,8'h1E,8'h00},
    '{8'h1E,8'h33,8'h33,8'h3E,8'h30,8'h18,8'h0E,8'h00},
    '{8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h00},
    '{8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h06},
    '{8'h18,8'h0C,8'h06,8'h03,8'h06,8'h0C,8'h18,8'h00},
    '{8'h00,8'h00,8'h3F,8'h00,8'h00,8'h3F,8'h00,8'h00},
    '{8'h06,8'h0C,8'h18,8'h30,8'h18,8'h0C,8'h06,8'h00},
    '{8'h1E,8'h33,8'h30,8'h18,8'h0C,8'h00,8'h0C,8'h00},
    '{8'h3E,8'h63,8'h7B,8'h7B,8'h7B,8'h03,8'h1E,8'h00},
    '{8'h0C,8'h1E,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h00},
    '{8'h3F,8'h66,8'h66,8'h3E,8'h66,8'h66,8'h3F,8'h00},
    '{8'h3C,8'h66,8'h03,8'h03,8'h03,8'h66,8'h3C,8'h00},
    '{8'h1F,8'h36,8'h66,8'h66,8'h66,8'h36,8'h1F,8'h00},
    '{8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h46,8'h7F,8'h00},
    '{8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h06,8'h0F,8'h00},
    '{8'h3C,8'h66,8'h03,8'h03,8'h73,8'h66,8'h7C,8'h00},
    '{8'h33,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h33,8'h00},
    '{8'h1E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
    '{8'h78,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E,8'h00},
    '{8'h67,8'h66,8'h36,8'h1E,8'h36,8'h66,8'h67,8'h00},
    '{8'h0F,8'h06,8'h06,8'h06,8'h46,8'h66,8'h7F,8'h00},
    '{8'h63,8'h77,8'h7F,8'h7F,8'h6B,8'h63,8'h63,8'h00},
    '{8'h63,8'h67,8'h6F,8'h7B,8'h73,8'h63,8'h63,8'h00},
    '{8'h1C,8'h36,8'h63,8'h63,8'h63,8'h36,8'h1C,8'h00},
    '{8'h3F,8'h66,8'h66,8'h3E,8'h06,8'h06,8'h0F,8'h00},
    '{8'h1E,8'h33,8'h33,8'h33,8'h3B,8'h1E,8'h38,8'h00},
    '{8'h3F,8'h66,8'h66,8'h3E,8'h36,8'h66,8'h67,8'h00},
    '{8'h1E,8'h33,8'h07,8'h0E,8'h38,8'h33,8'h1E,8'h00},
    '{8'h3F,8'h2D,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
    '{8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h3F,8'h00},
    '{8'h33,8'h33,8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h00},
    '{8'h63,8'h63,8'h63,8'h6B,8'h7F,8'h77,8'h63,8'h00},
    '{8'h63,8'h63,8'h36,8'h1C,8'h1C,8'h36,8'h63,8'h00},
    '{8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h0C,8'h1E,8'h00},
    '{8'h7F,8'h63,8'h31,8'h18,8'h4C,8'h66,8'h7F,8'h00},
    '{8'h1E,8'h06,8'h06,8'h06,8'h06,8'h06,8'h1E,8'h00},
    '{8'h03,8'h06,8'h0C,8'h18,8'h30,8'h60,8'h40,8'h00},
    '{8'h1E,8'h18,8'h18,8'h18,8'h18,8'h18,8'h1E,8'h00},
    '{8'h08,8'h1C,8'h36,8'h63,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hFF},
    '{8'h0C,8'h0C,8'h18,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h1E,8'h30,8'h3E,8'h33,8'h6E,8'h00},
    '{8'h07,8'h06,8'h06,8'h3E,8'h66,8'h66,8'h3B,8'h00},
    '{8'h00,8'h00,8'h1E,8'h33,8'h03,8'h33,8'h1E,8'h00},
    '{8'h38,8'h30,8'h30,8'h3E,8'h33,8'h33,8'h6E,8'h00},
    '{8'h00,8'h00,8'h1E,8'h33,8'h3F,8'h03,8'h1E,8'h00},
    '{8'h1C,8'h36,8'h06,8'h0F,8'h06,8'h06,8'h0F,8'h00},
    '{8'h00,8'h00,8'h6E,8'h33,8'h33,8'h3E,8'h30,8'h1F},
    '{8'h07,8'h06,8'h36,8'h6E,8'h66,8'h66,8'h67,8'h00},
    '{8'h0C,8'h00,8'h0E,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
    '{8'h30,8'h00,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E},
    '{8'h07,8'h06,8'h66,8'h36,8'h1E,8'h36,8'h67,8'h00},
    '{8'h0E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
    '{8'h00,8'h00,8'h33,8'h7F,8'h7F,8'h6B,8'h63,8'h00},
    '{8'h00,8'h00,8'h1F,8'h33,8'h33,8'h33,8'h33,8'h00},
    '{8'h00,8'h00,8'h1E,8'h33,8'h33,8'h33,8'h1E,8'h00},
    '{8'h00,8'h00,8'h3B,8'h66,8'h66,8'h3E,8'h06,8'h0F},
    '{8'h00,8'h00,8'h6E,8'h33,8'h33,8'h3E,8'h30,8'h78},
    '{8'h00,8'h00,8'h3B,8'h6E,8'h66,8'h06,8'h0F,8'h00},
    '{8'h00,8'h00,8'h3E,8'h03,8'h1E,8'h30,8'h1F,8'h00},
    '{8'h08,8'h0C,8'h3E,8'h0C,8'h0C,8'h2C,8'h18,8'h00},
    '{8'h00,8'h00,8'h33,8'h33,8'h33,8'h33,8'h6E,8'h00},
    '{8'h00,8'h00,8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h00},
    '{8'h00,8'h00,8'h63,8'h6B,8'h7F,8'h7F,8'h36,8'h00},
    '{8'h00,8'h00,8'h63,8'h36,8'h1C,8'h36,8'h63,8'h00},
    '{8'h00,8'h00,8'h33,8'h33,8'h33,8'h3E,8'h30,8'h1F},
    '{8'h00,8'h00,8'h3F,8'h19,8'h0C,8'h26,8'h3F,8'h00},
    '{8'h38,8'h0C,8'h0C,8'h07,8'h0C,8'h0C,8'h38,8'h00},
    '{8'h18,8'h18,8'h18,8'h00,8'h18,8'h18,8'h18,8'h00},
    '{8'h07,8'h0C,8'h0C,8'h38,8'h0C,8'h0C,8'h07,8'h00},
    '{8'h6E,8'h3B,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
  };

  // all 64 pixels of a glyph, row i at bits [8i+7:8i]; control codes and delete are blank
  function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [CODE_W-1:0] code);
    logic [GLYPH_BITS-1:0] bits;
    logic [CODE_W-1:0]     idx;
    bits = '0;
    idx  = code - CODE_W'(PRINT_FIRST);
    if (code >= CODE_W'(PRINT_FIRST) && code < CODE_W'(PRINT_FIRST + PRINT_COUNT)) begin
      for (int r = 0; r < GLYPH_SIZE; r++) begin
        bits[r*GLYPH_SIZE +: GLYPH_SIZE] = FONT_GLYPHS[idx][r];
      end
    end
    return bits;
  endfunction

endpackage

// File: sv/text_glyph_pixel_renderer_core.sv
// text console renderer: commands in, one pixel write per result item out
// a draw or backspace item shifts its 64 cell bits through a shift register, one bit a
// cycle, giving at most one pixel per cycle; scanning stops after the last set bit; output
// stalls hold the scan
// tab pre-wraps, then advances TAB_CELLS cells, one cell advance per cycle; newline and character ten act on accept
// reset (synchronous, active low) homes the cursor, sets screen_width to 1024, empties output
module text_glyph_pixel_renderer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tgpr_pkg::SW_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tgpr_pkg::OP_W-1:0]   in_opcode,
  input  logic [tgpr_pkg::CODE_W-1:0] in_char_code,
  input  logic [tgpr_pkg::COL_W-1:0]  in_color,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tgpr_pkg::PIX_W-1:0]  out_pixel_x,
  output logic [tgpr_pkg::PIX_W-1:0]  out_pixel_y,
  output logic [tgpr_pkg::COL_W-1:0]  out_pixel_color,
  output logic                        out_last
);
  import tgpr_pkg::*;

  localparam int POS_W = $clog2(GLYPH_BITS);
  localparam int SUB_W = $clog2(GLYPH_SIZE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAB
  } state_t;

  state_t               state_r;
  logic [SW_W-1:0]      screen_width_r;
  logic [GLYPH_BITS-1:0] bits_r;
  logic [POS_W-1:0]     pos_r;
  logic [COL_W-1:0]     color_r;
  logic                 is_glyph_r;
  logic [1:0]           tab_cnt_r;
  logic                 out_valid_r;
  logic [PIX_W-1:0]     pixel_x_r, pixel_y_r;
  logic [COL_W-1:0]     pixel_color_r;
  logic                 last_r;

  cur_cmd_t         cur_cmd;
  logic [CUR_W-1:0] cur_col, cur_row;
  logic             accept, step, scan_done, pix_fire;
  opcode_t          op;

  assign op        = opcode_t'(in_opcode);
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign step      = !out_valid_r || out_ready;
  // nothing left to draw after the current bit
  assign scan_done = ~|bits_r[GLYPH_BITS-1:1];
  assign pix_fire  = (state_r == ST_SCAN) && step && bits_r[0];

  always_comb begin
    cur_cmd = CUR_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_DRAW:      cur_cmd = (in_char_code == CODE_NEWLINE) ? CUR_NEWLINE : CUR_HOLD;
            OP_NEWLINE:   cur_cmd = CUR_NEWLINE;
            OP_BACKSPACE: cur_cmd = CUR_BACKSPACE;
            OP_TAB:       cur_cmd = CUR_TAB_WRAP;
            default:      cur_cmd = CUR_HOLD;
          endcase
        end
      end
      ST_SCAN: begin
        if (step && scan_done && is_glyph_r) cur_cmd = CUR_ADVANCE;
      end
      ST_TAB:  cur_cmd = CUR_ADVANCE;
      default: cur_cmd = CUR_HOLD;
    endcase
  end

  tgpr_cursor u_cursor (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cur_cmd),
    .screen_width (screen_width_r),
    .col          (cur_col),
    .row          (cur_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      screen_width_r <= SCREEN_WIDTH_RST;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) screen_width_r <= cfg_wdata;
      if (pix_fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            pos_r     <= '0;
            tab_cnt_r <= '0;
            unique case (op)
              OP_DRAW: begin
                bits_r     <= font_glyph(in_char_code);
                color_r    <= in_color;
                is_glyph_r <= 1'b1;
                if (in_char_code != CODE_NEWLINE) state_r <= ST_SCAN;
              end
              OP_BACKSPACE: begin
                bits_r     <= '1;
                color_r    <= '0;
                is_glyph_r <= 1'b0;
                state_r    <= ST_SCAN;
              end
              OP_TAB:  state_r <= ST_TAB;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (step) begin
            if (bits_r[0]) begin
              pixel_x_r     <= PIX_W'(cur_col) + PIX_W'(MARGIN) + PIX_W'(pos_r[SUB_W-1:0]);
              pixel_y_r     <= PIX_W'(cur_row) + PIX_W'(MARGIN) + PIX_W'(pos_r[POS_W-1:SUB_W]);
              pixel_color_r <= color_r;
              last_r        <= scan_done;
            end
            bits_r <= bits_r >> 1;
            pos_r  <= pos_r + POS_W'(1);
            if (scan_done) state_r <= ST_IDLE;
          end
        end
        ST_TAB: begin
          tab_cnt_r <= tab_cnt_r + 2'd1;
          if (tab_cnt_r == 2'(TAB_CELLS - 1)) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pixel_x_r;
  assign out_pixel_y     = pixel_y_r;
  assign out_pixel_color = pixel_color_r;
  assign out_last        = last_r;

endmodule

// File: sv/tgpr_cursor.sv
// text cursor position: newline, cell advance with line wrap, backspace, tab pre-wrap
module tgpr_cursor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tgpr_pkg::cur_cmd_t         cmd,
  input  logic [tgpr_pkg::SW_W-1:0]  screen_width,
  output logic [tgpr_pkg::CUR_W-1:0] col,
  output logic [tgpr_pkg::CUR_W-1:0] row
);
  import tgpr_pkg::*;

  localparam int CMP_W = CUR_W + 2;

  logic [CUR_W-1:0]        col_r, col_nxt;
  logic [CUR_W-1:0]        row_r, row_nxt;
  logic [CUR_W-1:0]        col_adv;
  logic signed [CMP_W-1:0] sw_s;
  logic signed [CMP_W-1:0] lim_one, lim_tab;
  logic                    wrap_one, wrap_tab;

  // wrap thresholds go negative on a tiny screen, so compare signed
  assign sw_s    = $signed(CMP_W'(screen_width));
  assign lim_one = sw_s - CMP_W'(MARGIN + GLYPH_SIZE);
  assign lim_tab = sw_s - CMP_W'(MARGIN + TAB_CELLS * GLYPH_SIZE);
  assign col_adv = col_r + CUR_W'(GLYPH_SIZE);
  assign wrap_one = $signed(CMP_W'(col_adv)) >= lim_one;
  assign wrap_tab = $signed(CMP_W'(col_r)) >= lim_tab;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    unique case (cmd)
      CUR_HOLD: ;
      CUR_NEWLINE: begin
        col_nxt = '0;
        row_nxt = row_r + CUR_W'(GLYPH_SIZE + LINE_PAD);
      end
      CUR_ADVANCE: begin
        if (wrap_one) begin
          col_nxt = '0;
          row_nxt = row_r + CUR_W'(GLYPH_SIZE + LINE_PAD);
        end else begin
          col_nxt = col_adv;
        end
      end
      CUR_BACKSPACE: begin
        if (col_r >= CUR_W'(GLYPH_SIZE)) begin
          col_nxt = col_r - CUR_W'(GLYPH_SIZE);
        end else if (row_r > CUR_W'(GLYPH_SIZE) && col_r == '0) begin
          row_nxt = row_r - CUR_W'(GLYPH_SIZE);
        end
      end
      CUR_TAB_WRAP: begin
        if (wrap_tab) begin
          col_nxt = '0;
          row_nxt = row_r + CUR_W'(GLYPH_SIZE + LINE_PAD);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;
  assign row = row_r;

endmodule
